// ===== rtl/core/vpss_pkg.sv =====
`timescale 1ns / 1ps

package vpss_pkg;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam logic [3:0] ADDR_PORT_B     = 4'h0;
  localparam logic [3:0] ADDR_PORT_A     = 4'h1;
  localparam logic [3:0] ADDR_DIR_B      = 4'h2;
  localparam logic [3:0] ADDR_DIR_A      = 4'h3;
  localparam logic [3:0] ADDR_PORT_A_ALT = 4'hF;

  localparam logic [7:0] REG_RESET = 8'hFF;
  localparam int unsigned NUM_REGS = 16;

  typedef struct packed {
    logic       opcode;
    logic [3:0] reg_address;
    logic [7:0] write_byte;
    logic       speech_ready;
    logic       speech_irq;
    logic [7:0] speech_status;
  } req_t;

  typedef struct packed {
    logic [7:0] read_byte;
    logic       speech_send;
    logic [7:0] speech_byte;
    logic [7:0] port_b_lines;
  } rsp_t;

  function automatic logic [7:0] merge_outputs(logic [7:0] cur, logic [7:0] val,
                                               logic [7:0] dir);
    return (cur & ~dir) | (val & dir);
  endfunction

endpackage

// ===== rtl/core/vpss_req_if.sv =====
`timescale 1ns / 1ps

interface vpss_req_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [3:0] reg_address;
  logic [7:0] write_byte;
  logic       speech_ready;
  logic       speech_irq;
  logic [7:0] speech_status;

  modport source (output valid, opcode, reg_address, write_byte, speech_ready,
                  speech_irq, speech_status, input ready);
  modport sink (input valid, opcode, reg_address, write_byte, speech_ready,
                speech_irq, speech_status, output ready);
endinterface

// ===== rtl/core/vpss_rsp_if.sv =====
`timescale 1ns / 1ps

interface vpss_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_byte;
  logic       speech_send;
  logic [7:0] speech_byte;
  logic [7:0] port_b_lines;

  modport source (output valid, read_byte, speech_send, speech_byte, port_b_lines,
                  input ready);
  modport sink (input valid, read_byte, speech_send, speech_byte, port_b_lines,
                output ready);
endinterface

// ===== rtl/core/vpss_regs.sv =====
`timescale 1ns / 1ps

module vpss_regs
  import vpss_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic advance_i,
  input  req_t req_i,
  output rsp_t rsp_o
);

  logic [7:0] port_a_q, port_a_d;
  logic [7:0] port_b_q, port_b_d;
  logic [7:0] dir_a_q, dir_a_d;
  logic [7:0] dir_b_q, dir_b_d;
  logic [7:0] misc_q [NUM_REGS];
  logic       misc_we;
  logic       is_port_a;

  assign is_port_a = (req_i.reg_address == ADDR_PORT_A) ||
                     (req_i.reg_address == ADDR_PORT_A_ALT);

  always_comb begin
    port_a_d = port_a_q;
    port_b_d = port_b_q;
    dir_a_d  = dir_a_q;
    dir_b_d  = dir_b_q;
    misc_we  = 1'b0;
    rsp_o    = '0;
    if (req_i.opcode == OP_READ) begin
      if (req_i.reg_address == ADDR_PORT_B) begin
        rsp_o.read_byte = (port_b_q & dir_b_q) |
                          {4'b0, ~req_i.speech_irq, ~req_i.speech_ready, 2'b0};
      end else if (is_port_a) begin
        rsp_o.read_byte = port_a_q;
      end else if (req_i.reg_address == ADDR_DIR_B) begin
        rsp_o.read_byte = dir_b_q;
      end else if (req_i.reg_address == ADDR_DIR_A) begin
        rsp_o.read_byte = dir_a_q;
      end else begin
        rsp_o.read_byte = misc_q[req_i.reg_address];
      end
    end else begin
      if (req_i.reg_address == ADDR_PORT_B) begin
        port_b_d = merge_outputs(port_b_q, req_i.write_byte, dir_b_q);
        if (!port_b_q[0] && port_b_d[0]) begin
          rsp_o.speech_send = 1'b1;
          rsp_o.speech_byte = port_a_q;
        end
        if (!port_b_q[1] && port_b_d[1]) begin
          port_a_d = merge_outputs(req_i.speech_status, port_a_q, dir_a_q);
        end
      end else if (is_port_a) begin
        port_a_d = merge_outputs(port_a_q, req_i.write_byte, dir_a_q);
      end else if (req_i.reg_address == ADDR_DIR_B) begin
        dir_b_d = req_i.write_byte;
      end else if (req_i.reg_address == ADDR_DIR_A) begin
        dir_a_d = req_i.write_byte;
      end else begin
        misc_we = 1'b1;
      end
    end
    rsp_o.port_b_lines = port_b_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      port_a_q <= REG_RESET;
      port_b_q <= REG_RESET;
      dir_a_q  <= REG_RESET;
      dir_b_q  <= REG_RESET;
      for (int i = 0; i < NUM_REGS; i++) begin
        misc_q[i] <= REG_RESET;
      end
    end else if (advance_i) begin
      port_a_q <= port_a_d;
      port_b_q <= port_b_d;
      dir_a_q  <= dir_a_d;
      dir_b_q  <= dir_b_d;
      if (misc_we) begin
        misc_q[req_i.reg_address] <= req_i.write_byte;
      end
    end
  end

  a_port_a_inputs_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && req_i.opcode == OP_WRITE && is_port_a
    |=> (port_a_q & ~dir_a_q) == $past(port_a_q & ~dir_a_q))
    else $error("port A input bits changed by a data write");

  a_port_b_inputs_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance_i && req_i.opcode == OP_WRITE && req_i.reg_address == ADDR_PORT_B
    |=> (port_b_q & ~dir_b_q) == $past(port_b_q & ~dir_b_q))
    else $error("port B input bits changed by a data write");

  a_state_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance_i |=> $stable(port_a_q) && $stable(port_b_q) && $stable(dir_a_q)
                   && $stable(dir_b_q))
    else $error("port state changed without an access");

endmodule

// ===== rtl/core/via_ports_speech_strobe_unit.sv =====
`timescale 1ns / 1ps

// Speech front end built on a 6522-style pair of parallel ports.
// req_i carries one bus access per word: a read or a write to one of 16
// register addresses, plus the speech chip's ready, interrupt and status
// lines sampled for that access. rsp_o returns one word per access: the read
// data (zero on writes), the speech send strobe and byte, and port B after
// the access.
// An access accepted on req_i passes the input register, then the register
// update and result register in the same edge, to the word on rsp_o.
// Throughput is one access per cycle; req_i stays ready while the
// result register is empty or being drained.
// Reset sets the port, direction and spare registers to 0xFF and empties
// both stages. When the receiver stalls, the result holds, one further
// access waits in the input register, and req_i ready then drops.
module via_ports_speech_strobe_unit
  import vpss_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  vpss_req_if.sink           req_i,
  vpss_rsp_if.source         rsp_o
);

  logic in_valid_q;
  req_t in_q;
  logic out_valid_q;
  rsp_t out_q;
  rsp_t rsp_d;
  logic advance;
  logic in_ready;

  assign advance  = in_valid_q && (!out_valid_q || rsp_o.ready);
  assign in_ready = !in_valid_q || advance;
  assign req_i.ready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_q <= req_i.valid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && req_i.valid) begin
      in_q.opcode        <= req_i.opcode;
      in_q.reg_address   <= req_i.reg_address;
      in_q.write_byte    <= req_i.write_byte;
      in_q.speech_ready  <= req_i.speech_ready;
      in_q.speech_irq    <= req_i.speech_irq;
      in_q.speech_status <= req_i.speech_status;
    end
    if (advance) begin
      out_q <= rsp_d;
    end
  end

  vpss_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (advance),
    .req_i     (in_q),
    .rsp_o     (rsp_d)
  );

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.read_byte    = out_q.read_byte;
  assign rsp_o.speech_send  = out_q.speech_send;
  assign rsp_o.speech_byte  = out_q.speech_byte;
  assign rsp_o.port_b_lines = out_q.port_b_lines;

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready |-> in_valid_q && out_valid_q && !rsp_o.ready)
    else $error("input stalled while the pipeline could drain");

  a_send_after_edge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.speech_send |-> out_q.port_b_lines[0])
    else $error("speech send without port B bit 0 high");

  a_no_byte_without_send: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.speech_send |-> out_q.speech_byte == 8'h00)
    else $error("speech byte set without a send");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !rsp_o.ready |=> out_valid_q && $stable(out_q))
    else $error("stalled result word lost");

endmodule
